// ===== src/projection_centroid_finder_top_macros.svh =====
// Assertion macros for the projection centroid finder checker
`ifndef PROJECTION_CENTROID_FINDER_TOP_MACROS_SVH
`define PROJECTION_CENTROID_FINDER_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define PCF_ASSERT_NOW(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("pcf check failed");

// Next-cycle implication, off during reset
`define PCF_ASSERT_NEXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("pcf check failed");

`endif

// ===== src/pcf_pkg.sv =====
// Shared types and constants of the projection centroid finder
`default_nettype none

package pcf_pkg;

    localparam int CFG_W    = 13;
    localparam int PIX_W    = 16;
    localparam int CENTER_W = 20;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;

    typedef struct packed {
        logic take;        // pixel beat accepted this cycle
        logic walk_start;  // start a pass over the column sums
        logic walk_pass;   // 0: minimum pass, 1: weighted sum pass
        logic div_start;   // start one division
        logic div_row;     // division operands: 0 column, 1 row
        logic load;        // load result into output register, restart frame
    } pcf_cmd_t;

    typedef struct packed {
        logic frame_end;   // current position is the last pixel of the frame
        logic pipe_busy;   // pixel pipeline still writing
        logic walk_busy;   // column pass running
        logic div_busy;    // divider running
        logic flat;        // a background-subtracted total is zero
        logic out_free;    // output register can take a result
    } pcf_stat_t;

    // Zero counts as one, above the maximum counts as the maximum
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int unsigned max_v);
        logic [CFG_W-1:0] r;
        if (v == '0)
            r = CFG_W'(1);
        else if (32'(v) > max_v)
            r = CFG_W'(max_v);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/pcf_divider.sv =====
// Restoring divider, one quotient bit per cycle, saturated fixed-point result
`default_nettype none

module pcf_divider #(
    parameter int NUM_W     = 52,
    parameter int DEN_W     = 40,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [NUM_W-1:0]             num,
    input  wire logic [DEN_W-1:0]             den,
    output logic                              busy,
    output logic                              done,
    output logic [pcf_pkg::CENTER_W-1:0]      quo
);
    import pcf_pkg::*;

    localparam int NB    = NUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(NB + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NB-1:0]     n_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [CENTER_W-1:0] q_reg;
    logic              ovf_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    // Trial subtract of the next partial remainder
    always_comb
    begin
        trial = {rem_reg, n_reg[NB-1]};
        diff  = trial - {1'b0, den};
        ge    = trial >= {1'b0, den};
    end

    // Step the quotient one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            n_reg    <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NB);
                n_reg    <= NB'(num) << FRAC_BITS;
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                q_reg   <= {q_reg[CENTER_W-2:0], ge};
                ovf_reg <= ovf_reg | q_reg[CENTER_W-1];
                n_reg   <= n_reg << 1;
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = ovf_reg ? {CENTER_W{1'b1}} : q_reg;

endmodule

`default_nettype wire

// ===== src/pcf_datapath.sv =====
// Datapath: projections, column memory, background removal, division, output
`default_nettype none

module pcf_datapath #(
    parameter int MAX_COLS   = 4096,
    parameter int MAX_ROWS   = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcf_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic [pcf_pkg::PIX_W-1:0]       pixel,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic [pcf_pkg::CENTER_W-1:0]         center_col,
    output logic [pcf_pkg::CENTER_W-1:0]         center_row,
    output logic                                 status,
    input  wire pcf_pkg::pcf_cmd_t               cmd,
    output pcf_pkg::pcf_stat_t                   stat
);
    import pcf_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CS_W  = PIXEL_BITS + RW;
    localparam int RS_W  = PIXEL_BITS + CW;
    localparam int TOT_W = PIXEL_BITS + CW + RW;
    localparam int WT_W  = TOT_W + ((CW > RW) ? CW : RW);
    localparam int IW    = ((CW > CFG_W) ? CW : CFG_W) + 1;

    // Configuration
    logic [CFG_W-1:0] w_reg;
    logic [CFG_W-1:0] h_reg;

    // Raster position and row accumulation
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [RS_W-1:0]  row_acc_reg;
    logic             last_col;
    logic             last_row;
    logic [PIXEL_BITS-1:0] pix;
    logic [RS_W-1:0]  row_sum;

    // Finished row pipeline
    logic             rd_v_reg;
    logic [RS_W-1:0]  rd_sum_reg;
    logic [RW-1:0]    rd_row_reg;
    logic             pv_reg;
    logic [RW+RS_W-1:0] prod_r_reg;
    logic [RS_W-1:0]  least_reg;
    logic [TOT_W-1:0] all_reg;
    logic [WT_W-1:0]  rwt_tot_reg;

    // Column memory and its update stage
    logic [CS_W-1:0]  mem [MAX_COLS];
    logic [CS_W-1:0]  mem_rd_reg;
    logic [CW-1:0]    rd_addr;
    logic             s1_v_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_first_reg;
    logic             s1_fwd_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CS_W-1:0]  fwd_data_reg;
    logic [CS_W-1:0]  col_sum;

    // Column walk
    logic             wk_act_reg;
    logic [CW-1:0]    wk_reg;
    logic             pass_reg;
    logic             r1_v_reg;
    logic [CW-1:0]    r1_idx_reg;
    logic [CS_W-1:0]  cmin_reg;
    logic             d_v_reg;
    logic [CW-1:0]    d_idx_reg;
    logic [CS_W-1:0]  diff_reg;
    logic             p_v_reg;
    logic [CW+CS_W-1:0] prodc_reg;
    logic [TOT_W-1:0] ctot_reg;
    logic [WT_W-1:0]  cwt_reg;

    // Row background terms
    logic [RS_W+CFG_W-1:0]     m1_reg;
    logic [2*CFG_W-1:0]        m2_reg;
    logic [RS_W+2*CFG_W-2:0]   m3_reg;
    logic [TOT_W-1:0]          rtot_reg;
    logic [WT_W-1:0]           rwt_reg;

    // Division
    logic             sel_row_reg;
    logic             div_sel;
    logic [WT_W-1:0]  div_num;
    logic [TOT_W-1:0] div_den;
    logic             div_busy;
    logic             div_done;
    logic [CENTER_W-1:0] div_quo;
    logic [CENTER_W-1:0] res_col_reg;
    logic [CENTER_W-1:0] res_row_reg;

    // Output register
    logic             out_valid_reg;
    logic [CENTER_W-1:0] center_col_reg;
    logic [CENTER_W-1:0] center_row_reg;
    logic             status_reg;

    logic             flat;

    // Capture frame size on a register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= clamp_dim(DIM_RESET, MAX_COLS);
            h_reg <= clamp_dim(DIM_RESET, MAX_ROWS);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                w_reg <= clamp_dim(cfg_data, MAX_COLS);
            else
                h_reg <= clamp_dim(cfg_data, MAX_ROWS);
        end
    end

    // Position decode
    always_comb
    begin
        pix      = pixel[PIXEL_BITS-1:0];
        last_col = IW'(col_reg) == (IW'(w_reg) - IW'(1));
        last_row = IW'(row_reg) == (IW'(h_reg) - IW'(1));
        row_sum  = row_acc_reg + RS_W'(pix);
    end

    // Advance the raster position and the row sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_acc_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            row_acc_reg <= '0;
        end
        else if (cmd.take)
        begin
            if (last_col)
            begin
                col_reg     <= '0;
                row_reg     <= last_row ? '0 : row_reg + RW'(1);
                row_acc_reg <= '0;
            end
            else
            begin
                col_reg     <= col_reg + CW'(1);
                row_acc_reg <= row_sum;
            end
        end
    end

    // Finished rows: minimum, total and index-weighted total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg    <= 1'b0;
            rd_sum_reg  <= '0;
            rd_row_reg  <= '0;
            pv_reg      <= 1'b0;
            prod_r_reg  <= '0;
            least_reg   <= '1;
            all_reg     <= '0;
            rwt_tot_reg <= '0;
        end
        else
        begin
            rd_v_reg   <= cmd.take && last_col;
            rd_sum_reg <= row_sum;
            rd_row_reg <= row_reg;
            pv_reg     <= rd_v_reg;
            prod_r_reg <= rd_row_reg * rd_sum_reg;
            if (cfg_we || cmd.load)
            begin
                least_reg   <= '1;
                all_reg     <= '0;
                rwt_tot_reg <= '0;
            end
            else
            begin
                if (rd_v_reg)
                begin
                    if (rd_sum_reg < least_reg)
                        least_reg <= rd_sum_reg;
                    all_reg <= all_reg + TOT_W'(rd_sum_reg);
                end
                if (pv_reg)
                    rwt_tot_reg <= rwt_tot_reg + WT_W'(prod_r_reg);
            end
        end
    end

    // Column update stage, with forwarding for a one-column frame
    always_comb
    begin
        if (s1_first_reg)
            col_sum = CS_W'(s1_pix_reg);
        else
            col_sum = (s1_fwd_reg ? fwd_data_reg : mem_rd_reg) + CS_W'(s1_pix_reg);
        rd_addr = wk_act_reg ? wk_reg : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s1_col_reg   <= '0;
            s1_first_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            s1_pix_reg   <= '0;
            fwd_data_reg <= '0;
        end
        else
        begin
            s1_v_reg     <= cmd.take;
            s1_col_reg   <= col_reg;
            s1_first_reg <= row_reg == '0;
            s1_fwd_reg   <= s1_v_reg && (s1_col_reg == col_reg);
            s1_pix_reg   <= pix;
            if (s1_v_reg)
                fwd_data_reg <= col_sum;
        end
    end

    // Column sum memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
            mem[s1_col_reg] <= col_sum;
        mem_rd_reg <= mem[rd_addr];
    end

    // Walk the column sums: minimum pass, then weighted sum pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wk_act_reg <= 1'b0;
            wk_reg     <= '0;
            pass_reg   <= 1'b0;
            r1_v_reg   <= 1'b0;
            r1_idx_reg <= '0;
            cmin_reg   <= '0;
            d_v_reg    <= 1'b0;
            d_idx_reg  <= '0;
            diff_reg   <= '0;
            p_v_reg    <= 1'b0;
            prodc_reg  <= '0;
            ctot_reg   <= '0;
            cwt_reg    <= '0;
        end
        else
        begin
            if (cmd.walk_start)
            begin
                wk_act_reg <= 1'b1;
                wk_reg     <= '0;
                pass_reg   <= cmd.walk_pass;
                ctot_reg   <= '0;
                cwt_reg    <= '0;
            end
            else if (wk_act_reg)
            begin
                wk_reg <= wk_reg + CW'(1);
                if (IW'(wk_reg) == (IW'(w_reg) - IW'(1)))
                    wk_act_reg <= 1'b0;
            end

            r1_v_reg   <= wk_act_reg;
            r1_idx_reg <= wk_reg;

            if (r1_v_reg && !pass_reg)
            begin
                if (r1_idx_reg == '0 || mem_rd_reg < cmin_reg)
                    cmin_reg <= mem_rd_reg;
            end

            d_v_reg   <= r1_v_reg && pass_reg;
            d_idx_reg <= r1_idx_reg;
            diff_reg  <= mem_rd_reg - cmin_reg;

            p_v_reg   <= d_v_reg;
            prodc_reg <= d_idx_reg * diff_reg;
            if (d_v_reg)
                ctot_reg <= ctot_reg + TOT_W'(diff_reg);
            if (p_v_reg)
                cwt_reg <= cwt_reg + WT_W'(prodc_reg);
        end
    end

    // Row background terms from the row minimum, row totals and frame height
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg   <= '0;
            m2_reg   <= '0;
            m3_reg   <= '0;
            rtot_reg <= '0;
            rwt_reg  <= '0;
        end
        else
        begin
            m1_reg   <= least_reg * h_reg;
            m2_reg   <= h_reg * (h_reg - CFG_W'(1));
            m3_reg   <= least_reg * m2_reg[2*CFG_W-1:1];
            rtot_reg <= all_reg - TOT_W'(m1_reg);
            rwt_reg  <= rwt_tot_reg - WT_W'(m3_reg);
        end
    end

    assign flat = (rtot_reg == '0) || (ctot_reg == '0);

    // Division operands: follow the command at start, then hold the selection
    always_comb
    begin
        div_sel = cmd.div_start ? cmd.div_row : sel_row_reg;
        div_num = div_sel ? rwt_reg : cwt_reg;
        div_den = div_sel ? rtot_reg : ctot_reg;
    end

    pcf_divider #(
        .NUM_W     (WT_W),
        .DEN_W     (TOT_W),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_row_reg <= 1'b0;
            res_col_reg <= '0;
            res_row_reg <= '0;
        end
        else
        begin
            if (cmd.div_start)
                sel_row_reg <= cmd.div_row;
            if (div_done)
            begin
                if (sel_row_reg)
                    res_row_reg <= div_quo;
                else
                    res_col_reg <= div_quo;
            end
        end
    end

    // Output register: load a result, drop it once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            center_col_reg <= '0;
            center_row_reg <= '0;
            status_reg     <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg  <= 1'b1;
            center_col_reg <= flat ? '0 : res_col_reg;
            center_row_reg <= flat ? '0 : res_row_reg;
            status_reg     <= flat;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign center_col = center_col_reg;
    assign center_row = center_row_reg;
    assign status     = status_reg;

    // Status to the controller
    always_comb
    begin
        stat.frame_end = last_col && last_row;
        stat.pipe_busy = s1_v_reg || rd_v_reg || pv_reg;
        stat.walk_busy = wk_act_reg || r1_v_reg || d_v_reg || p_v_reg;
        stat.div_busy  = div_busy;
        stat.flat      = flat;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

// ===== src/pcf_ctrl.sv =====
// Controller: frame intake, column passes, division sequence, result load
`default_nettype none

module pcf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output pcf_pkg::pcf_cmd_t        cmd,
    input  wire pcf_pkg::pcf_stat_t  stat
);
    import pcf_pkg::*;

    localparam logic [3:0] S_RUN   = 4'd0;
    localparam logic [3:0] S_DRAIN = 4'd1;
    localparam logic [3:0] S_MIN   = 4'd2;
    localparam logic [3:0] S_SUM   = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_DIVC  = 4'd5;
    localparam logic [3:0] S_DIVR  = 4'd6;
    localparam logic [3:0] S_LOAD  = 4'd7;

    localparam logic [1:0] FIN_LAST = 2'd3;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] fin_cnt_reg;
    logic [1:0] fin_cnt_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        fin_cnt_next = fin_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_RUN:
            begin
                cmd.take = in_valid;
                if (in_valid && stat.frame_end)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_pass  = 1'b0;
                    state_next     = S_MIN;
                end
            end
            S_MIN:
            begin
                if (!stat.walk_busy)
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_pass  = 1'b1;
                    state_next     = S_SUM;
                end
            end
            S_SUM:
            begin
                if (!stat.walk_busy)
                begin
                    fin_cnt_next = '0;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                fin_cnt_next = fin_cnt_reg + 2'd1;
                if (fin_cnt_reg == FIN_LAST)
                begin
                    if (stat.flat)
                        state_next = S_LOAD;
                    else
                    begin
                        cmd.div_start = 1'b1;
                        cmd.div_row   = 1'b0;
                        state_next    = S_DIVC;
                    end
                end
            end
            S_DIVC:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_row   = 1'b1;
                    state_next    = S_DIVR;
                end
            end
            S_DIVR:
            begin
                if (!stat.div_busy)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_RUN;
            fin_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            fin_cnt_reg <= fin_cnt_next;
        end
    end

    // Hold off pixels outside frame intake
    assign in_stall = state_reg != S_RUN;

endmodule

`default_nettype wire

// ===== src/projection_centroid_finder_top.sv =====
// Top level of the projection centroid finder
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------------
//  pixel    | in        | in_valid / in_stall   | pixel
//  result   | out       | out_valid / out_stall | center_col, center_row, status
//  config   | in        | cfg_we                | cfg_index, cfg_data
//
//  Pixels are taken one per cycle inside a frame.
//  After the last pixel the input stalls for the pipeline drain, two passes over the
//  column memory (one read port), then, unless the frame is flat, two bit-serial
//  divisions of 60 quotient bits, one bit per cycle.
//  A result waits in the output register; the next frame is taken meanwhile, and its
//  end stalls further until the waiting result is taken.
//  Reset leaves the frame size at 4096 by 4096; the column memory needs no clear.
`default_nettype none

module projection_centroid_finder_top #(
    parameter int MAX_COLS   = 4096,
    parameter int MAX_ROWS   = 4096,
    parameter int PIXEL_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [pcf_pkg::PIX_W-1:0]       pixel,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [pcf_pkg::CENTER_W-1:0]         center_col,
    output logic [pcf_pkg::CENTER_W-1:0]         center_row,
    output logic                                 status,
    input  wire logic                            cfg_we,
    input  wire logic [pcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pcf_pkg::CFG_W-1:0]       cfg_data
);
    import pcf_pkg::*;

    pcf_cmd_t  cmd;
    pcf_stat_t stat;

    pcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    pcf_datapath #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .PIXEL_BITS (PIXEL_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (pixel),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .center_col (center_col),
        .center_row (center_row),
        .status     (status),
        .cmd        (cmd),
        .stat       (stat)
    );

endmodule

`default_nettype wire

// ===== src/pcf_checker.sv =====
// Port-level checker for the projection centroid finder, bound to the top level
`default_nettype none

`include "projection_centroid_finder_top_macros.svh"

module pcf_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic [pcf_pkg::PIX_W-1:0]       pixel,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [pcf_pkg::CENTER_W-1:0]    center_col,
    input wire logic [pcf_pkg::CENTER_W-1:0]    center_row,
    input wire logic                            status,
    input wire logic                            cfg_we,
    input wire logic [pcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [pcf_pkg::CFG_W-1:0]       cfg_data
);
    logic unused_ok;
    assign unused_ok = ^{pixel, cfg_we, cfg_index, cfg_data};

    // Stalled result beat stays
    `PCF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // Stalled result payload holds
    `PCF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(center_col) && $stable(center_row) && $stable(status))
    // Flat frame reports zero centers
    `PCF_ASSERT_NOW(a_flat_zero, clk, rst_n, out_valid && status, center_col == '0 && center_row == '0)
    // A new result never follows a pixel beat directly
    `PCF_ASSERT_NOW(a_rise_after_walk, clk, rst_n, $rose(out_valid), !$past(in_valid && !in_stall))

endmodule

bind projection_centroid_finder_top pcf_checker u_pcf_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for the projection centroid finder: random frames checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

class centroid_scoreboard;
    logic [19:0] want_col[$];
    logic [19:0] want_row[$];
    logic        want_flat[$];
    int          errors;
    int          matched;

    // Predictor state
    int unsigned width_reg;
    int unsigned height_reg;
    longint unsigned col_acc[4096];
    longint unsigned row_acc;
    longint unsigned row_floor;
    longint unsigned rows_sum;
    longint unsigned rows_wsum;
    int unsigned     cur_col;
    int unsigned     cur_row;

    function new();
        errors = 0;
        matched = 0;
        width_reg = 4096;
        height_reg = 4096;
        foreach (col_acc[i]) col_acc[i] = 0;
        restart();
    endfunction

    function void restart();
        row_acc = 0;
        row_floor = (64'd1 << 28) - 1;
        rows_sum = 0;
        rows_wsum = 0;
        cur_col = 0;
        cur_row = 0;
    endfunction

    function void write_reg(logic idx, logic [12:0] val);
        if (idx == pcf_pkg::REG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        restart();
    endfunction

    function int unsigned limit_dim(int unsigned v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function logic [19:0] fix_quot(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q > (20'hFFFFF >> 8)) return 20'hFFFFF;
        for (int b = 0; b < 8; b++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r -= den;
                q |= 1;
            end
        end
        return (q > 20'hFFFFF) ? 20'hFFFFF : q[19:0];
    endfunction

    // Note one accepted pixel beat
    function void note_pixel(logic [15:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        longint unsigned cmin;
        longint unsigned ctot;
        longint unsigned cwt;
        longint unsigned rtot;
        longint unsigned rwt;
        w = limit_dim(width_reg);
        h = limit_dim(height_reg);
        c = cur_col;
        if (c >= w) c = w - 1;
        if (cur_row >= h) cur_row = h - 1;
        row_acc += px;
        if (cur_row == 0) col_acc[c] = px;
        else col_acc[c] += px;
        if (c + 1 < w)
        begin
            cur_col = c + 1;
            return;
        end
        if (row_acc < row_floor) row_floor = row_acc;
        rows_sum += row_acc;
        rows_wsum += longint'(cur_row) * row_acc;
        row_acc = 0;
        cur_col = 0;
        if (cur_row + 1 < h)
        begin
            cur_row++;
            return;
        end
        cmin = col_acc[0];
        for (int i = 1; i < w; i++)
            if (col_acc[i] < cmin) cmin = col_acc[i];
        ctot = 0;
        cwt = 0;
        for (int i = 0; i < w; i++)
        begin
            ctot += col_acc[i] - cmin;
            cwt += longint'(i) * (col_acc[i] - cmin);
        end
        rtot = rows_sum - row_floor * h;
        rwt = rows_wsum - row_floor * ((longint'(h) * (h - 1)) / 2);
        if (rtot == 0 || ctot == 0)
        begin
            want_col.push_back('0);
            want_row.push_back('0);
            want_flat.push_back(1'b1);
        end
        else
        begin
            want_col.push_back(fix_quot(cwt, ctot));
            want_row.push_back(fix_quot(rwt, rtot));
            want_flat.push_back(1'b0);
        end
        restart();
    endfunction

    // Check one accepted result beat
    function void check_result(logic [19:0] col, logic [19:0] row, logic flat);
        logic [19:0] ec;
        logic [19:0] er;
        logic        ef;
        if (want_col.size() == 0)
        begin
            $display("%0t: unexpected result col=%h row=%h status=%b",
                     $time, col, row, flat);
            errors++;
            return;
        end
        ec = want_col.pop_front();
        er = want_row.pop_front();
        ef = want_flat.pop_front();
        if (col !== ec)
        begin
            $display("%0t: center_col expected %h actual %h", $time, ec, col);
            errors++;
        end
        if (row !== er)
        begin
            $display("%0t: center_row expected %h actual %h", $time, er, row);
            errors++;
        end
        if (flat !== ef)
        begin
            $display("%0t: status expected %b actual %b", $time, ef, flat);
            errors++;
        end
        matched++;
    endfunction
endclass

module testbench;
    import pcf_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [PIX_W-1:0]  pixel;
    logic              out_valid;
    logic              out_stall;
    logic [CENTER_W-1:0] center_col;
    logic [CENTER_W-1:0] center_row;
    logic              status;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    centroid_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int pixels_sent;
    int frames_seen;

    projection_centroid_finder_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .center_col(center_col), .center_row(center_row), .status(status),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Drain results with random stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(center_col, center_row, status);
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Send one pixel beat, with an optional idle gap first; valid stays up
    // until the next beat or a drain replaces it in the same time step
    task automatic send_pixel(logic [15:0] px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_pixel(px);
        pixels_sent++;
    endtask

    // Wait until all results are in, then let the block settle
    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (board.want_col.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (2 * 4096 + 200) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_frame(logic [12:0] w, logic [12:0] h);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // One frame; kind picks the content style
    task automatic send_frame(int unsigned w, int unsigned h, int kind);
        int unsigned pc;
        int unsigned pr;
        logic [15:0] base;
        base = 16'($urandom);
        pc = $urandom_range(w - 1);
        pr = $urandom_range(h - 1);
        for (int r = 0; r < h; r++)
            for (int c = 0; c < w; c++)
                case (kind)
                    0: send_pixel(base);
                    1: send_pixel((r == pr && c == pc) ? 16'hFFFF : 16'h0000);
                    2: send_pixel(16'($urandom_range(255)) +
                                  ((r == pr || c == pc) ? 16'h8000 : 16'h0));
                    default: send_pixel(16'($urandom));
                endcase
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int phase_pixels;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        pixel = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pixels_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, flat frames, zero-counts-as-one, over-maximum clamp
        write_reg(REG_FRAME_WIDTH, 13'd3);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        send_pixel(16'h0000); send_pixel(16'hFFFF); send_pixel(16'h0001);
        send_pixel(16'h8000); send_pixel(16'h7FFF); send_pixel(16'hFFFF);
        send_pixel(16'h0000); send_pixel(16'h5555); send_pixel(16'hAAAA);
        send_frame(3, 3, 0);
        set_frame(13'd1, 13'd4);
        send_frame(1, 4, 3);
        set_frame(13'd0, 13'd0);
        send_pixel(16'hFFFF);
        set_frame(13'd5, 13'd1);
        send_frame(5, 1, 3);
        // Abandon a frame part way through
        set_frame(13'd2, 13'd2);
        send_pixel(16'h1234);
        set_frame(13'd2, 13'd2);
        send_frame(2, 2, 1);
        set_frame(13'h1FFF, 13'd1);
        send_frame(4096, 1, 3);
        set_frame(13'd1, 13'd4096);
        send_frame(1, 4096, 1);

        // Random frames, three idling phases
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 80 : 0;
            recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 8 : 0;
            phase_pixels = 0;
            while (phase_pixels < 700)
            begin
                w = $urandom_range(2, 12);
                h = $urandom_range(2, 12);
                set_frame(13'(w), 13'(h));
                repeat ($urandom_range(1, 4))
                begin
                    send_frame(w, h, $urandom_range(3));
                    phase_pixels += int'(w * h);
                end
            end
        end
        drain();

        $display("Sent %0d pixels; %0d frame results checked over 3 idling phases.",
                 pixels_sent, board.matched);
        if (board.errors == 0 && board.want_col.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Run limit
    initial
    begin
        #40ms;
        $display("FAILURE");
        $finish;
    end
endmodule

`default_nettype wire

// ===== projection_centroid_finder_top.f =====
+incdir+src
src/pcf_pkg.sv
src/pcf_divider.sv
src/pcf_datapath.sv
src/pcf_ctrl.sv
src/projection_centroid_finder_top.sv
src/pcf_checker.sv
dv/testbench.sv
